>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LIFO store RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define LSS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lss_pkg.sv
// ---------------------------------------------------------------------------
// LIFO store package
// Types and constants shared by the LIFO store with search.
// ---------------------------------------------------------------------------
package lss_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned Q_DEPTH   = 2;
	localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH     = 2'd0,
		OP_POP      = 2'd1,
		OP_SEARCH   = 2'd2,
		OP_TRAVERSE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		B_IDLE = 1'b0,
		B_SCAN = 1'b1
	} back_state_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t                       op;
		logic                      scan;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

endpackage

>>> rtl/core/lss_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation and its value.
// ---------------------------------------------------------------------------
interface lss_req_if;
	logic                               valid;
	logic                               ready;
	lss_pkg::op_t                       op;
	logic signed [lss_pkg::VALUE_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

>>> rtl/core/lss_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result of the LIFO store.
// ---------------------------------------------------------------------------
interface lss_rsp_if;
	logic                               valid;
	logic                               ready;
	lss_pkg::status_t                   status;
	logic                               found;
	logic signed [lss_pkg::VALUE_W-1:0] entry_value;
	logic                               last;

	modport source (output valid, output status, output found, output entry_value,
		output last, input ready);
	modport sink (input valid, input status, input found, input entry_value,
		input last, output ready);
endinterface

>>> rtl/core/lss_front.sv
// ---------------------------------------------------------------------------
// LIFO store front end
// Registers incoming requests, tags scan operations, feeds the queue.
// ---------------------------------------------------------------------------
module lss_front (
	input  logic          clk,
	input  logic          arst_n,
	lss_req_if.sink       req,
	output logic          q_valid,
	input  logic          q_ready,
	output lss_pkg::cmd_t q_cmd
);

	logic          vld_s1;
	lss_pkg::cmd_t cmd_s1;
	logic          take;

	// stage is free when empty or draining into the queue
	assign req.ready = !vld_s1 || q_ready;
	assign take      = req.valid && req.ready;
	assign q_valid   = vld_s1;
	assign q_cmd     = cmd_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// classify: search and traverse walk the store
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op    <= req.op;
			cmd_s1.scan  <= (req.op == lss_pkg::OP_SEARCH) ||
				(req.op == lss_pkg::OP_TRAVERSE);
			cmd_s1.value <= req.value;
		end
	end

endmodule

>>> rtl/core/lss_cmdq.sv
// ---------------------------------------------------------------------------
// LIFO store command queue
// Short FIFO decoupling the front end from the execution back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  lss_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output lss_pkg::cmd_t pop_cmd
);

	lss_pkg::cmd_t                mem_q [lss_pkg::Q_DEPTH];
	logic [lss_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [lss_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [lss_pkg::Q_CW-1:0]     cnt_q;
	logic                         full;
	logic                         empty;
	logic                         wr;
	logic                         rd;

	assign full       = (cnt_q == lss_pkg::Q_CW'(lss_pkg::Q_DEPTH));
	assign empty      = (cnt_q == '0);
	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign wr         = push_valid && !full;
	assign rd         = pop && !empty;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == lss_pkg::Q_AW'(lss_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == lss_pkg::Q_AW'(lss_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	`LSS_ASSERT_ALWAYS(a_no_pop_empty, clk, arst_n, !(pop && empty), "pop from empty queue")
	`LSS_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, (cnt_q <= lss_pkg::Q_CW'(lss_pkg::Q_DEPTH)),
		"queue count over depth")
	`LSS_ASSERT_NEXT(a_cnt_track, clk, arst_n, (wr && !rd), (cnt_q == $past(cnt_q) + 1'b1),
		"queue count did not follow a write")

endmodule

>>> rtl/core/lss_back.sv
// ---------------------------------------------------------------------------
// LIFO store back end
// Executes push, pop, search and traverse against the entry memory.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_back #(
	parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  lss_pkg::cmd_t q_cmd,
	lss_rsp_if.source     rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned VW = lss_pkg::VALUE_W;

	logic signed [VW-1:0]  mem [DEPTH];

	lss_pkg::back_state_t  state_q, state_d;
	logic [CW-1:0]         fill_q, fill_d;
	logic [CW-1:0]         rem_q, rem_d;
	logic [CW-1:0]         rem_dec;
	logic                  hit_q, hit_d;
	lss_pkg::op_t          op_q;
	logic signed [VW-1:0]  val_q;

	logic                  s1_vld_q, s1_vld_d;
	logic                  last_s1;
	logic signed [VW-1:0]  data_s1;

	logic                  ov_q;
	lss_pkg::status_t      status_q;
	logic                  found_q;
	logic signed [VW-1:0]  entry_q;
	logic                  last_q;

	logic                  out_free;
	logic                  start;
	logic                  full;
	logic                  empty;
	logic                  s1_adv;
	logic                  issue;
	logic                  we;
	logic                  load;
	lss_pkg::status_t      ld_status;
	logic                  ld_found;
	logic signed [VW-1:0]  ld_entry;
	logic                  ld_last;

	assign out_free = !ov_q || rsp.ready;
	assign start    = (state_q == lss_pkg::B_IDLE) && q_valid && out_free;
	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign rem_dec  = rem_q - 1'b1;
	// search only waits on the output for its final compare
	assign s1_adv   = (op_q == lss_pkg::OP_SEARCH) ? (!last_s1 || out_free) : out_free;

	// next state and result selection
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		rem_d     = rem_q;
		hit_d     = hit_q;
		s1_vld_d  = s1_vld_q;
		q_pop     = 1'b0;
		we        = 1'b0;
		issue     = 1'b0;
		load      = 1'b0;
		ld_status = lss_pkg::ST_OK;
		ld_found  = 1'b0;
		ld_entry  = '0;
		ld_last   = 1'b1;
		case (state_q)
			lss_pkg::B_IDLE: begin
				if (start) begin
					q_pop = 1'b1;
					if (q_cmd.scan) begin
						if (empty) begin
							load      = 1'b1;
							ld_status = lss_pkg::ST_EMPTY;
						end else begin
							state_d = lss_pkg::B_SCAN;
							rem_d   = fill_q;
							hit_d   = 1'b0;
						end
					end else if (q_cmd.op == lss_pkg::OP_PUSH) begin
						load = 1'b1;
						if (full) begin
							ld_status = lss_pkg::ST_FULL;
						end else begin
							we     = 1'b1;
							fill_d = fill_q + 1'b1;
						end
					end else begin
						load = 1'b1;
						if (empty) begin
							ld_status = lss_pkg::ST_EMPTY;
						end else begin
							fill_d = fill_q - 1'b1;
						end
					end
				end
			end
			lss_pkg::B_SCAN: begin
				// read one entry a cycle while the read stage advances, top first
				issue = (rem_q != '0) && (!s1_vld_q || s1_adv);
				if (issue) begin
					rem_d    = rem_dec;
					s1_vld_d = 1'b1;
				end else if (s1_adv) begin
					s1_vld_d = 1'b0;
				end
				if (s1_vld_q && s1_adv) begin
					if (op_q == lss_pkg::OP_SEARCH) begin
						hit_d = hit_q || (data_s1 == val_q);
						if (last_s1) begin
							load     = 1'b1;
							ld_found = hit_d;
							state_d  = lss_pkg::B_IDLE;
						end
					end else begin
						load     = 1'b1;
						ld_entry = data_s1;
						ld_last  = last_s1;
						if (last_s1) begin
							state_d = lss_pkg::B_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = lss_pkg::B_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lss_pkg::B_IDLE;
			fill_q   <= '0;
			rem_q    <= '0;
			hit_q    <= 1'b0;
			s1_vld_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			rem_q    <= rem_d;
			hit_q    <= hit_d;
			s1_vld_q <= s1_vld_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// latched operation for a scan
	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= q_cmd.op;
			val_q <= q_cmd.value;
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[fill_q[AW-1:0]] <= q_cmd.value;
		end
		if (issue) begin
			data_s1 <= mem[rem_dec[AW-1:0]];
			last_s1 <= (rem_q == CW'(1));
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= ld_status;
			found_q  <= ld_found;
			entry_q  <= ld_entry;
			last_q   <= ld_last;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = status_q;
	assign rsp.found       = found_q;
	assign rsp.entry_value = entry_q;
	assign rsp.last        = last_q;

	`LSS_ASSERT_ALWAYS(a_fill_range, clk, arst_n, (fill_q <= CW'(DEPTH)), "fill count over depth")
	`LSS_ASSERT_ALWAYS(a_s1_in_scan, clk, arst_n, (!s1_vld_q || (state_q == lss_pkg::B_SCAN)),
		"read data pending outside scan")
	`LSS_ASSERT_NEXT(a_push_grows, clk, arst_n, we, (fill_q == $past(fill_q) + 1'b1),
		"push did not grow fill count")

endmodule

>>> rtl/core/lifo_store_with_search_top.sv
// Push, pop and empty-store answers pass the front stage register, the command queue and the
// output register; search and traversal also pass the scan read register of the entry memory.
// Throughput: push/pop one per cycle while responses are accepted; search/traverse hold the back end
// for the whole scan, bounded by the single read port of the entry memory.
// Reset (arst_n, async, active low) empties the store and all queues; entries stay unset.
// ---------------------------------------------------------------------------
// LIFO store with search, top level
// Front end, command queue and execution back end of a bounded value stack.
// ---------------------------------------------------------------------------
module lifo_store_with_search_top #(
	parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lss_req_if.sink   cmd,
	lss_rsp_if.source rsp
);

	logic          f_valid;
	logic          f_ready;
	lss_pkg::cmd_t f_cmd;
	logic          b_valid;
	logic          b_pop;
	lss_pkg::cmd_t b_cmd;

	lss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cmd),
		.q_valid (f_valid),
		.q_ready (f_ready),
		.q_cmd   (f_cmd)
	);

	lss_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop        (b_pop),
		.pop_cmd    (b_cmd)
	);

	lss_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (b_valid),
		.q_pop   (b_pop),
		.q_cmd   (b_cmd),
		.rsp     (rsp)
	);

endmodule
